@@ rtl/udiv64_pkg.sv @@
// Shared types for the 64-bit unsigned divider.
`timescale 1ns / 1ps
package udiv64_pkg;
	// Sideband that rides along the division pipeline
	typedef struct packed {
		logic pow2;
		logic dbz;
	} side_t;
endpackage

@@ rtl/udiv64_stage.sv @@
// One radix-2 restoring division step with its pipeline register.
`timescale 1ns / 1ps
module udiv64_stage #(
	parameter int W = 64,
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [W-1:0]        in_num,
	input  logic [W-1:0]        in_den,
	input  logic [W-1:0]        in_quo,
	input  logic [W-1:0]        in_rem,
	input  logic [W-1:0]        in_aux,
	input  logic [$clog2(W+1)-1:0] in_k,
	input  udiv64_pkg::side_t   in_side,
	output logic                out_valid,
	output logic [W-1:0]        out_num,
	output logic [W-1:0]        out_den,
	output logic [W-1:0]        out_quo,
	output logic [W-1:0]        out_rem,
	output logic [W-1:0]        out_aux,
	output logic [$clog2(W+1)-1:0] out_k,
	output udiv64_pkg::side_t   out_side
);
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         take;
	// Shift in the next numerator bit and trial-subtract
	always_comb begin
		trial = {in_rem, in_num[BIT]};
		diff  = trial - {1'b0, in_den};
		take  = !diff[W];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_num  <= in_num;
			out_den  <= in_den;
			out_quo  <= {in_quo[W-2:0], take};
			out_rem  <= take ? diff[W-1:0] : trial[W-1:0];
			out_aux  <= in_aux;
			out_k    <= in_k;
			out_side <= in_side;
		end
	end
endmodule

@@ rtl/udiv64_quotient_remainder_top.sv @@
// Top level of the pipelined 64-bit unsigned divider.
//
// Operands enter on the s_axis channel as one beat: dividend in the low
// DATA_WIDTH bits of tdata, divisor above it. Results leave on m_axis:
// quotient low, remainder above it, divide_by_zero in tuser.
// The divisor is normalized to its odd part in a first stage, then one
// restoring step per stage runs the division, DATA_WIDTH stages, then a
// final stage rebuilds the remainder and picks the power-of-two or
// zero-divisor result. One beat enters every cycle while the receiver
// does not stall the output.
// The whole pipeline advances together: when the receiver stalls with a
// result at the output, every stage holds and s_axis_tready drops; a
// bubble at the output lets the pipeline advance. Reset clears all valid
// bits so the output is empty afterward.
`timescale 1ns / 1ps
module udiv64_quotient_remainder_top #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// dividend, divisor
	input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// quotient, remainder
	output logic [2*DATA_WIDTH-1:0] m_axis_tdata,
	// divide_by_zero
	output logic                    m_axis_tuser
);
	localparam int W = DATA_WIDTH;
	localparam int KW = $clog2(W + 1);

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [W-1:0] x, y;
	assign x = s_axis_tdata[W-1:0];
	assign y = s_axis_tdata[2*W-1:W];

	// Count trailing zeros of the divisor
	logic [KW-1:0] tz;
	always_comb begin
		tz = KW'(W);
		for (int i = W - 1; i >= 0; i--) begin
			if (y[i]) tz = KW'(i);
		end
	end

	logic [W-1:0] odd;
	assign odd = y >> tz;

	// Stage zero: normalize and split
	logic [W-1:0] c_valid_dummy;
	logic          v_s1;
	logic [W-1:0]  num_s1, den_s1, aux_s1;
	logic [KW-1:0] k_s1;
	udiv64_pkg::side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= (y == '0) ? x : (x >> tz);
			den_s1 <= (y == '0) ? {{(W-1){1'b0}}, 1'b1} : odd;
			aux_s1 <= x;
			k_s1   <= tz;
			side_s1.dbz  <= (y == '0);
			side_s1.pow2 <= (odd == {{(W-1){1'b0}}, 1'b1});
		end
	end
	assign c_valid_dummy = '0;

	logic          v_c [W+1];
	logic [W-1:0]  num_c [W+1], den_c [W+1], quo_c [W+1], rem_c [W+1], aux_c [W+1];
	logic [KW-1:0] k_c [W+1];
	udiv64_pkg::side_t side_c [W+1];
	assign v_c[0] = v_s1;
	assign num_c[0] = num_s1;
	assign den_c[0] = den_s1;
	assign quo_c[0] = c_valid_dummy;
	assign rem_c[0] = '0;
	assign aux_c[0] = aux_s1;
	assign k_c[0] = k_s1;
	assign side_c[0] = side_s1;

	// Division chain, most significant bit first
	for (genvar g = 0; g < W; g++) begin : g_step
		udiv64_stage #(.W(W), .BIT(W - 1 - g)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v_c[g]), .in_num(num_c[g]), .in_den(den_c[g]),
			.in_quo(quo_c[g]), .in_rem(rem_c[g]), .in_aux(aux_c[g]),
			.in_k(k_c[g]), .in_side(side_c[g]),
			.out_valid(v_c[g+1]), .out_num(num_c[g+1]), .out_den(den_c[g+1]),
			.out_quo(quo_c[g+1]), .out_rem(rem_c[g+1]), .out_aux(aux_c[g+1]),
			.out_k(k_c[g+1]), .out_side(side_c[g+1])
		);
	end

	// Final stage: rebuild remainder and select special cases
	logic [W-1:0] lmask, q_f, r_f;
	always_comb begin
		lmask = ~({W{1'b1}} << k_c[W]);
		if (side_c[W].dbz) begin
			q_f = '1;
			r_f = aux_c[W];
		end else if (side_c[W].pow2) begin
			q_f = num_c[W];
			r_f = aux_c[W] & lmask;
		end else begin
			q_f = quo_c[W];
			r_f = (rem_c[W] << k_c[W]) | (aux_c[W] & lmask);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_c[W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {r_f, q_f};
			m_axis_tuser <= side_c[W].dbz;
		end
	end
endmodule
